>>> rtl/fbrq_pkg.sv
// ----------------------------------------------------------------------------
// fbrq_pkg
// Shared widths, codes and reset values for the frame buffer recycle queues.
// ----------------------------------------------------------------------------
`default_nettype none

package fbrq_pkg;

  localparam int CMD_W    = 3;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam int MAX_BUFFERS_DEF = 16;

  localparam logic [CFG_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CAM_PUSH_READY = 3'd0,
    CMD_CAM_POP_FREE   = 3'd1,
    CMD_CLI_PUSH_FREE  = 3'd2,
    CMD_CLI_POP_READY  = 3'd3,
    CMD_RESET          = 3'd4
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

`default_nettype wire

>>> rtl/fbrq_if.sv
// ----------------------------------------------------------------------------
// fbrq_if
// Request and result channels of the frame buffer recycle queues.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbrq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [fbrq_pkg::CMD_W-1:0]  command;
  logic [fbrq_pkg::IDX_W-1:0]  push_index;

  modport source (output valid, output command, output push_index, input ready);
  modport sink   (input valid, input command, input push_index, output ready);
endinterface

interface fbrq_res_if;
  logic                          valid;
  logic                          ready;
  logic [fbrq_pkg::STATUS_W-1:0] status;
  logic [fbrq_pkg::IDX_W-1:0]    pop_index;

  modport source (output valid, output status, output pop_index, input ready);
  modport sink   (input valid, input status, input pop_index, output ready);
endinterface

`default_nettype wire

>>> rtl/fbrq_ram.sv
// ----------------------------------------------------------------------------
// fbrq_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbrq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/frame_buffer_recycle_queues.sv
// Path: an accepted request goes to the request stage, then to the result register.
// Throughput: one request per cycle, held back only by a stalled result.
// The request stage covers the registered read of the ring RAMs.
// Reset: rst sets the buffer count to 16, fills the free queue with 0..n-1
// through per-entry valid bits (no clearing pass) and empties the ready queue.
// ----------------------------------------------------------------------------
// frame_buffer_recycle_queues
// Free and ready queues of frame buffer indices sharing one wrap length.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_recycle_queues #(
  parameter int MAX_BUFFERS = fbrq_pkg::MAX_BUFFERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  fbrq_cmd_if.sink                         cmd,
  fbrq_res_if.source                       res,
  input  wire logic                        cfg_wr_en,
  input  wire logic [fbrq_pkg::CFG_W-1:0]  cfg_wr_data
);

  import fbrq_pkg::*;

  localparam int AW      = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int CNT_W   = $clog2(MAX_BUFFERS + 1);
  localparam int RESET_N = (int'(COUNT_RESET) > MAX_BUFFERS) ? MAX_BUFFERS
                                                             : int'(COUNT_RESET);

  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] n;
    if (v == '0) begin
      n = CNT_W'(1);
    end else if (32'(v) > 32'(MAX_BUFFERS)) begin
      n = CNT_W'(MAX_BUFFERS);
    end else begin
      n = CNT_W'(v);
    end
    return n;
  endfunction

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0]    base,
                                             input logic [CNT_W-1:0] step,
                                             input logic [CNT_W-1:0] n);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(step);
    if (sum >= {1'b0, n}) begin
      sum = sum - {1'b0, n};
    end
    return AW'(sum);
  endfunction

  // configuration and queue state
  logic [CFG_W-1:0]       buffer_count;
  logic [AW-1:0]          free_head, free_head_next;
  logic [CNT_W-1:0]       free_fill, free_fill_next;
  logic [AW-1:0]          ready_head, ready_head_next;
  logic [CNT_W-1:0]       ready_fill, ready_fill_next;
  logic [MAX_BUFFERS-1:0] free_valid;

  // request stage (ring read in flight) and result register
  logic                   s1_valid;
  status_t                s1_status;
  logic                   s1_pop_ok;
  logic                   s1_from_free;
  logic                   s1_entry_valid;
  logic [IDX_W-1:0]       s1_fallback;
  logic                   res_valid;
  status_t                res_status;
  logic [IDX_W-1:0]       res_pop_index;

  logic                   accept;
  logic                   s1_adv;
  logic [CNT_W-1:0]       n;
  status_t                status_now;
  logic                   pop_ok_now;
  logic                   from_free_now;
  logic                   queue_reset;

  logic                   free_we, free_re;
  logic [AW-1:0]          free_waddr;
  logic [IDX_W-1:0]       free_rdata;
  logic                   ready_we, ready_re;
  logic [AW-1:0]          ready_waddr;
  logic [IDX_W-1:0]       ready_rdata;

  assign n      = active_count(buffer_count);
  assign s1_adv = !res_valid || res.ready;
  assign accept = cmd.valid && cmd.ready;

  assign cmd.ready     = !s1_valid || s1_adv;
  assign res.valid     = res_valid;
  assign res.status    = res_status;
  assign res.pop_index = res_pop_index;

  always_comb begin
    status_now      = ST_OK;
    pop_ok_now      = 1'b0;
    from_free_now   = 1'b0;
    queue_reset     = cfg_wr_en;
    free_we         = 1'b0;
    free_re         = 1'b0;
    free_waddr      = wrap_add(free_head, free_fill, n);
    ready_we        = 1'b0;
    ready_re        = 1'b0;
    ready_waddr     = wrap_add(ready_head, ready_fill, n);
    free_head_next  = free_head;
    free_fill_next  = free_fill;
    ready_head_next = ready_head;
    ready_fill_next = ready_fill;
    if (accept) begin
      case (cmd.command)
        CMD_CAM_PUSH_READY: begin
          if (ready_fill >= n) begin
            status_now = ST_FULL;
          end else begin
            ready_we        = 1'b1;
            ready_fill_next = ready_fill + CNT_W'(1);
          end
        end
        CMD_CAM_POP_FREE: begin
          if (free_fill == '0) begin
            status_now = ST_EMPTY;
          end else begin
            free_re        = 1'b1;
            pop_ok_now     = 1'b1;
            from_free_now  = 1'b1;
            free_head_next = wrap_add(free_head, CNT_W'(1), n);
            free_fill_next = free_fill - CNT_W'(1);
          end
        end
        CMD_CLI_PUSH_FREE: begin
          if (free_fill >= n) begin
            status_now = ST_FULL;
          end else begin
            free_we        = 1'b1;
            free_fill_next = free_fill + CNT_W'(1);
          end
        end
        CMD_CLI_POP_READY: begin
          if (ready_fill == '0) begin
            status_now = ST_EMPTY;
          end else begin
            ready_re        = 1'b1;
            pop_ok_now      = 1'b1;
            ready_head_next = wrap_add(ready_head, CNT_W'(1), n);
            ready_fill_next = ready_fill - CNT_W'(1);
          end
        end
        CMD_RESET: begin
          queue_reset     = 1'b1;
          free_head_next  = '0;
          free_fill_next  = n;
          ready_head_next = '0;
          ready_fill_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_count <= COUNT_RESET;
      free_head    <= '0;
      free_fill    <= CNT_W'(RESET_N);
      ready_head   <= '0;
      ready_fill   <= '0;
    end else if (cfg_wr_en) begin
      buffer_count <= cfg_wr_data;
      free_head    <= '0;
      free_fill    <= active_count(cfg_wr_data);
      ready_head   <= '0;
      ready_fill   <= '0;
    end else begin
      free_head    <= free_head_next;
      free_fill    <= free_fill_next;
      ready_head   <= ready_head_next;
      ready_fill   <= ready_fill_next;
    end
  end

  // an entry not written since the last refill reads as its own index
  always_ff @(posedge clk) begin
    if (rst || queue_reset) begin
      free_valid <= '0;
    end else if (free_we) begin
      free_valid[free_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status      <= status_now;
      s1_pop_ok      <= pop_ok_now;
      s1_from_free   <= from_free_now;
      s1_entry_valid <= free_valid[free_head];
      s1_fallback    <= IDX_W'(free_head);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      res_status <= s1_status;
      if (!s1_pop_ok) begin
        res_pop_index <= '0;
      end else if (!s1_from_free) begin
        res_pop_index <= ready_rdata;
      end else if (s1_entry_valid) begin
        res_pop_index <= free_rdata;
      end else begin
        res_pop_index <= s1_fallback;
      end
    end
  end

  fbrq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BUFFERS)
  ) u_free_ring (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (cmd.push_index),
    .re    (free_re),
    .raddr (free_head),
    .rdata (free_rdata)
  );

  fbrq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BUFFERS)
  ) u_ready_ring (
    .clk   (clk),
    .we    (ready_we),
    .waddr (ready_waddr),
    .wdata (cmd.push_index),
    .re    (ready_re),
    .raddr (ready_head),
    .rdata (ready_rdata)
  );

endmodule

`default_nettype wire
